// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/fcpp_pkg.sv =====
// Package for the framed command packet parser: register map, reset values, action codes.
// No dependencies.
package fcpp_pkg;

    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;

    localparam logic [2:0] REG_FRAME  = 3'd0;
    localparam logic [2:0] REG_NODES  = 3'd1;
    localparam logic [2:0] REG_BCAST  = 3'd2;
    localparam logic [2:0] REG_CMDS   = 3'd3;
    localparam logic [2:0] REG_LMASK  = 3'd4;

    localparam logic [7:0]  RST_FRAME = 8'h7E;
    localparam logic [23:0] RST_NODES = 24'h030201;
    localparam logic [7:0]  RST_BCAST = 8'hFF;
    localparam logic [31:0] RST_CMDS  = 32'h88884611;
    localparam logic [7:0]  RST_LMASK = 8'h0F;

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_SINGLE = 2'd1;
    localparam logic [1:0] ACT_GROUP  = 2'd2;

endpackage

// ===== design/framed_command_packet_parser_top.sv =====
// Timing: an accepted byte is registered at the input, parsed from that register, and its
// result, if any, is registered at the output. Throughput: one byte per cycle, set by the
// single parse stage; only output backpressure stalls the input.
// Reset: synchronous, active low; registers return to defaults, parser waits for a frame byte.
// Top level of the framed command packet parser. Depends on fcpp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module framed_command_packet_parser_top
    import fcpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_action,
    output logic [7:0]           o_dest_address,
    output logic [7:0]           o_param_index,
    output logic [15:0]          o_param_value,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrW-1:0]     paddr,
    input  logic [DataW-1:0]     pwdata,
    output logic [DataW-1:0]     prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {
        S_START,
        S_ADDRESS,
        S_COMMAND,
        S_DATA,
        S_CHECK
    } t_state;

    logic [7:0]  r_frame;
    logic [23:0] r_nodes;
    logic [7:0]  r_bcast;
    logic [31:0] r_cmds;
    logic [7:0]  r_lmask;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_state      r_state, n_state;
    logic [7:0]  r_count, n_count;
    logic        r_armed, n_armed;
    logic [7:0]  r_last, n_last;
    logic [7:0]  r_pkt_addr, n_pkt_addr;
    logic [7:0]  r_pkt_cmd, n_pkt_cmd;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_plen, n_plen;
    logic [7:0]  r_param, n_param;
    logic [7:0]  r_val_hi, n_val_hi;
    logic [7:0]  r_val_lo, n_val_lo;

    logic        n_res_valid;
    logic [1:0]  n_res_action;
    logic [15:0] n_res_value;

    logic        r_out_valid;
    logic [1:0]  r_out_action;
    logic [7:0]  r_out_addr;
    logic [7:0]  r_out_param;
    logic [15:0] r_out_value;

    logic        en;
    logic        cfg_wr;
    logic        addr_ok;
    logic        cmd_ok;
    logic        stuff_hit;
    logic [7:0]  b;
    logic [7:0]  cnt_inc;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_action       = r_out_action;
    assign o_dest_address = r_out_addr;
    assign o_param_index  = r_out_param;
    assign o_param_value  = r_out_value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[4:2])
            REG_FRAME: prdata = {24'd0, r_frame};
            REG_NODES: prdata = {8'd0, r_nodes};
            REG_BCAST: prdata = {24'd0, r_bcast};
            REG_CMDS:  prdata = r_cmds;
            REG_LMASK: prdata = {24'd0, r_lmask};
            default:   prdata = '0;
        endcase
    end

    assign b       = r_in_byte;
    assign addr_ok = (b == r_nodes[7:0]) || (b == r_nodes[15:8]) || (b == r_nodes[23:16])
                     || (b == r_bcast);
    assign cmd_ok  = (b == r_cmds[7:0]) || (b == r_cmds[15:8]) || (b == r_cmds[23:16])
                     || (b == r_cmds[31:24]);
    assign stuff_hit = r_armed && (r_count != 8'd0) && (r_last == r_frame);
    assign cnt_inc   = r_count + 8'd1;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_armed      = r_armed;
        n_last       = r_last;
        n_pkt_addr   = r_pkt_addr;
        n_pkt_cmd    = r_pkt_cmd;
        n_check      = r_check;
        n_plen       = r_plen;
        n_param      = r_param;
        n_val_hi     = r_val_hi;
        n_val_lo     = r_val_lo;
        n_res_valid  = 1'b0;
        n_res_action = ACT_SET;
        n_res_value  = 16'd0;
        case (r_state)
            S_ADDRESS: begin
                if (addr_ok) begin
                    n_pkt_addr = b;
                    n_state    = S_COMMAND;
                end else if (b == r_frame) begin
                    n_state = S_ADDRESS;
                end else begin
                    n_state = S_START;
                end
            end
            S_COMMAND: begin
                if (cmd_ok) begin
                    n_pkt_cmd = b;
                    n_check   = b;
                    n_plen    = b & r_lmask;
                    n_count   = 8'd0;
                    n_state   = S_DATA;
                end else if (b == r_frame) begin
                    n_state = S_ADDRESS;
                end else begin
                    n_state = S_START;
                end
            end
            S_DATA: begin
                n_check = r_check ^ b;
                if (stuff_hit) begin
                    if (b == r_frame) begin
                        n_armed = 1'b0;
                        n_state = (r_count >= r_plen) ? S_CHECK : S_DATA;
                    end else begin
                        // lone frame byte: resync, this byte is the address
                        n_pkt_addr = b;
                        n_state    = S_COMMAND;
                    end
                end else begin
                    n_armed = 1'b1;
                    case (r_count)
                        8'd1:    n_param  = b;
                        8'd2:    n_val_hi = b;
                        8'd3:    n_val_lo = b;
                        default: n_param  = r_param;
                    endcase
                    n_last  = b;
                    n_count = cnt_inc;
                    n_state = (cnt_inc >= r_plen) ? S_CHECK : S_DATA;
                end
            end
            S_CHECK: begin
                if (r_check == b) begin
                    if (r_pkt_addr == r_bcast) begin
                        if (r_pkt_cmd == r_cmds[23:16]) begin
                            n_res_valid  = 1'b1;
                            n_res_action = ACT_SET;
                            n_res_value  = {r_val_hi, r_val_lo};
                        end
                    end else if (r_pkt_cmd == r_cmds[7:0]) begin
                        n_res_valid  = 1'b1;
                        n_res_action = ACT_SINGLE;
                    end else if (r_pkt_cmd == r_cmds[15:8]) begin
                        n_res_valid  = 1'b1;
                        n_res_action = ACT_GROUP;
                    end
                end
                n_state = S_START;
            end
            default: begin
                n_state = (b == r_frame) ? S_ADDRESS : S_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame      <= RST_FRAME;
            r_nodes      <= RST_NODES;
            r_bcast      <= RST_BCAST;
            r_cmds       <= RST_CMDS;
            r_lmask      <= RST_LMASK;
            r_in_valid   <= 1'b0;
            r_in_byte    <= 8'd0;
            r_state      <= S_START;
            r_count      <= 8'd0;
            r_armed      <= 1'b1;
            r_last       <= 8'd0;
            r_pkt_addr   <= 8'd0;
            r_pkt_cmd    <= 8'd0;
            r_check      <= 8'd0;
            r_plen       <= 8'd0;
            r_param      <= 8'd0;
            r_val_hi     <= 8'd0;
            r_val_lo     <= 8'd0;
            r_out_valid  <= 1'b0;
            r_out_action <= ACT_SET;
            r_out_addr   <= 8'd0;
            r_out_param  <= 8'd0;
            r_out_value  <= 16'd0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_FRAME: r_frame <= pwdata[7:0];
                    REG_NODES: r_nodes <= pwdata[23:0];
                    REG_BCAST: r_bcast <= pwdata[7:0];
                    REG_CMDS:  r_cmds  <= pwdata;
                    REG_LMASK: r_lmask <= pwdata[7:0];
                    default:   r_frame <= r_frame;
                endcase
            end
            if (en) begin
                r_in_valid  <= i_valid;
                r_in_byte   <= i_rx_byte;
                r_out_valid <= r_in_valid && n_res_valid;
                if (r_in_valid) begin
                    r_state      <= n_state;
                    r_count      <= n_count;
                    r_armed      <= n_armed;
                    r_last       <= n_last;
                    r_pkt_addr   <= n_pkt_addr;
                    r_pkt_cmd    <= n_pkt_cmd;
                    r_check      <= n_check;
                    r_plen       <= n_plen;
                    r_param      <= n_param;
                    r_val_hi     <= n_val_hi;
                    r_val_lo     <= n_val_lo;
                    r_out_action <= n_res_action;
                    r_out_addr   <= r_pkt_addr;
                    r_out_param  <= r_param;
                    r_out_value  <= n_res_value;
                end
            end
        end
    end

    `ASSERT_SAME(a_value_only_on_set, i_clk, i_rst_n,
        o_valid && (o_action != ACT_SET), o_param_value == 16'd0)
    `ASSERT_SAME(a_set_is_broadcast, i_clk, i_rst_n,
        o_valid && (o_action == ACT_SET), o_dest_address == r_bcast)
    `ASSERT_NEXT(a_result_from_check, i_clk, i_rst_n,
        en && !(r_in_valid && (r_state == S_CHECK)), !o_valid)

endmodule
